/* src/fsrc_pkg.sv */
// Package for the framed serial receiver: phase and result kind codes,
// the event record passed from parser to output, and the CRC-16 byte update.
// No dependencies.
`timescale 1ns / 1ps

package fsrc_pkg;

    localparam logic [7:0]  SOF_BYTE      = 8'h23;  // '#'
    localparam logic [7:0]  SYNC_BYTE     = 8'h53;  // 'S'
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam int          BITS_PER_BYTE = 8;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SYNC    = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_CRC_LO  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_STRAY   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_GOOD    = 2'd2,
        KIND_BAD     = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] frame_length;
        logic [7:0] data;
        kind_t      kind;
    } evt_t;

    // CRC-16/XMODEM, MSB first, one whole byte folded in.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < BITS_PER_BYTE; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* src/fsrc_front.sv */
// Parser front end: tracks the frame phase, length count and running CRC,
// and turns each accepted byte into at most one event. Depends on fsrc_pkg.
`timescale 1ns / 1ps

module fsrc_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_accept,
    input  logic [7:0]     in_byte,
    output logic           evt_valid,
    output fsrc_pkg::evt_t evt
);
    import fsrc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  exp_len_reg, exp_len_next;
    logic [7:0]  rcv_cnt_reg, rcv_cnt_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  cnt_inc;

    assign cnt_inc = rcv_cnt_reg + 8'd1;

    always_comb begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        rcv_cnt_next = rcv_cnt_reg;
        crc_hi_next  = crc_hi_reg;
        crc_next     = crc_reg;
        if (in_accept) begin
            unique case (phase_reg)
                PH_SYNC: begin
                    if (in_byte == SYNC_BYTE) begin
                        phase_next = PH_LEN;
                    end else if (in_byte != SOF_BYTE) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_LEN: begin
                    exp_len_next = in_byte;
                    rcv_cnt_next = '0;
                    crc_next     = '0;
                    phase_next   = (in_byte == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    crc_next     = crc16_byte(crc_reg, in_byte);
                    rcv_cnt_next = cnt_inc;
                    if (cnt_inc >= exp_len_reg) begin
                        phase_next = PH_CRC_HI;
                    end
                end
                PH_CRC_HI: begin
                    crc_hi_next = in_byte;
                    phase_next  = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    // Idle, and the unused codes behave the same way.
                    phase_next = (in_byte == SOF_BYTE) ? PH_SYNC : PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        evt_valid        = 1'b0;
        evt.kind         = KIND_STRAY;
        evt.data         = in_byte;
        evt.frame_length = '0;
        unique case (phase_reg)
            PH_SYNC: begin
                evt_valid = in_accept && (in_byte != SYNC_BYTE) && (in_byte != SOF_BYTE);
            end
            PH_LEN, PH_CRC_HI: begin
                evt_valid = 1'b0;
            end
            PH_PAYLOAD: begin
                evt_valid = in_accept;
                evt.kind  = KIND_PAYLOAD;
            end
            PH_CRC_LO: begin
                evt_valid        = in_accept;
                evt.kind         = ({crc_hi_reg, in_byte} == crc_reg) ? KIND_GOOD : KIND_BAD;
                evt.data         = '0;
                evt.frame_length = exp_len_reg;
            end
            default: begin
                evt_valid = in_accept && (in_byte != SOF_BYTE);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
        exp_len_reg <= exp_len_next;
        rcv_cnt_reg <= rcv_cnt_next;
        crc_hi_reg  <= crc_hi_next;
        crc_reg     <= crc_next;
    end

endmodule

/* src/fsrc_queue.sv */
// Short event queue between the parser and the output stage.
// Depends on fsrc_pkg for the event record.
`timescale 1ns / 1ps

module fsrc_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fsrc_pkg::evt_t push_evt,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output fsrc_pkg::evt_t head_evt
);
    import fsrc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    evt_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_evt  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_evt;
        end
    end

endmodule

/* src/fsrc_back.sv */
// Output stage: registers the head event of the queue onto the result stream.
// Depends on fsrc_pkg for the event record.
`timescale 1ns / 1ps

module fsrc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_not_empty,
    input  fsrc_pkg::evt_t q_evt,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output fsrc_pkg::evt_t out_evt
);
    import fsrc_pkg::*;

    logic out_valid_reg, out_valid_next;
    evt_t out_evt_reg;

    // Take a new item whenever the register is empty or being drained.
    assign q_pop = q_not_empty && (!out_valid_reg || out_ready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (q_pop) begin
            out_evt_reg <= q_evt;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_evt   = out_evt_reg;

endmodule

/* src/framed_serial_receiver_crc16.sv */
// Framed serial receiver with CRC-16/XMODEM check. Each input item is one received byte;
// the block hunts for frames of '#', 'S', a length byte, that many payload bytes and a
// two-byte CRC (high byte first). Payload bytes come out as they arrive, each frame ends
// with a good or bad verdict carrying the frame length, and bytes that break the start
// pattern come out as stray bytes. One byte is accepted every clock cycle; the parser
// folds each whole byte into the CRC as it is accepted. A result is written into the event
// queue when its byte is accepted and passes from there into the output register, which
// presents it on the output. Input is held off only when the queue is full because the
// output is stalled.
// Depends on fsrc_pkg, fsrc_front, fsrc_queue and fsrc_back.
`timescale 1ns / 1ps

module framed_serial_receiver_crc16 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data, [15:8] frame_length
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);
    import fsrc_pkg::*;

    logic in_accept;
    logic evt_valid;
    evt_t evt;
    logic q_full;
    logic q_not_empty;
    evt_t q_evt;
    logic q_pop;
    evt_t out_evt;

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    fsrc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_axis_tdata),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    fsrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (evt_valid),
        .push_evt  (evt),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_evt  (q_evt)
    );

    fsrc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_evt       (q_evt),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_evt     (out_evt)
    );

    assign m_axis_tdata = {out_evt.frame_length, out_evt.data};
    assign m_axis_tuser = out_evt.kind;

endmodule

/* tb/sv/framed_serial_receiver_crc16_tb.sv */
// Self-checking testbench for framed_serial_receiver_crc16: it streams bytes with random gaps
// and output stalls and predicts the stray, payload and verdict items in step.
// Depends on fsrc_pkg and the framed_serial_receiver_crc16 RTL.
`timescale 1ns / 1ps

module framed_serial_receiver_crc16_tb;
    import fsrc_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 700;

    typedef struct {
        logic [7:0] rx_byte;
        int         gap;
        bit         drain;
    } rx_item_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] frame_length;
    } frame_evt_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    rx_item_t   rx_bytes_q[$];
    frame_evt_t frame_evt_q[$];

    // Predictor state.
    phase_t      hunt_phase   = PH_IDLE;
    logic [7:0]  want_len     = 8'h00;
    logic [7:0]  got_len      = 8'h00;
    logic [7:0]  crc_hi_rx    = 8'h00;
    logic [15:0] crc_acc      = 16'h0000;

    int       err_count     = 0;
    int       quiet_cycles  = 0;
    bit       s_took        = 1'b0;
    bit       m_took        = 1'b0;
    bit       tx_busy       = 1'b0;
    int       tx_wait       = -1;
    rx_item_t tx_cur;
    int       rx_wait       = 0;
    bit       rx_burst      = 1'b1;
    int       rx_mode_left  = 0;
    bit       gen_burst     = 1'b1;
    int       gen_mode_left = 0;

    framed_serial_receiver_crc16 u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Bit-serial form of the XMODEM update: each message bit is folded in against the top bit.
    function automatic logic [15:0] xmodem_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            if (r[15] ^ b[i]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic void push_evt(input kind_t k, input logic [7:0] d, input logic [7:0] len);
        frame_evt_t ev;
        ev.kind         = k;
        ev.data         = d;
        ev.frame_length = len;
        frame_evt_q.insert(frame_evt_q.size(), ev);
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        case (hunt_phase)
            PH_SYNC: begin
                if (b == SYNC_BYTE) begin
                    hunt_phase = PH_LEN;
                end else if (b != SOF_BYTE) begin
                    hunt_phase = PH_IDLE;
                    push_evt(KIND_STRAY, b, 8'h00);
                end
            end
            PH_LEN: begin
                want_len   = b;
                got_len    = 8'h00;
                crc_acc    = 16'h0000;
                hunt_phase = (b == 8'h00) ? PH_CRC_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                crc_acc = xmodem_fold(crc_acc, b);
                got_len = got_len + 8'd1;
                if (got_len >= want_len) begin
                    hunt_phase = PH_CRC_HI;
                end
                push_evt(KIND_PAYLOAD, b, 8'h00);
            end
            PH_CRC_HI: begin
                crc_hi_rx  = b;
                hunt_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                hunt_phase = PH_IDLE;
                push_evt(({crc_hi_rx, b} == crc_acc) ? KIND_GOOD : KIND_BAD, 8'h00, want_len);
            end
            default: begin
                if (b == SOF_BYTE) begin
                    hunt_phase = PH_SYNC;
                end else begin
                    hunt_phase = PH_IDLE;
                    push_evt(KIND_STRAY, b, 8'h00);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    task automatic check_result();
        frame_evt_t ev;
        if (frame_evt_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item kind %0d data %02h length %0d",
                                      m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]));
        end else begin
            ev = frame_evt_q.pop_front();
            if (m_axis_tuser != ev.kind) begin
                report_mismatch($sformatf("kind %0d, expected %s", m_axis_tuser, ev.kind.name()));
            end
            if (m_axis_tdata[7:0] != ev.data) begin
                report_mismatch($sformatf("data %02h, expected %02h", m_axis_tdata[7:0], ev.data));
            end
            if (m_axis_tdata[15:8] != ev.frame_length) begin
                report_mismatch($sformatf("frame length %0d, expected %0d",
                                          m_axis_tdata[15:8], ev.frame_length));
            end
        end
    endtask

    // Gaps come in stretches: some runs of items go back to back, others wait at random.
    task automatic add_byte(input logic [7:0] b, input bit drain);
        rx_item_t it;
        if (gen_mode_left == 0) begin
            gen_burst     = !gen_burst;
            gen_mode_left = $urandom_range(15, 60);
        end
        gen_mode_left--;
        it.rx_byte = b;
        it.gap     = gen_burst ? 0 : $urandom_range(0, 13);
        it.drain   = drain;
        rx_bytes_q.insert(rx_bytes_q.size(), it);
    endtask

    task automatic add_frame(input logic [7:0] body[$], input bit corrupt, input bit drain_first);
        logic [15:0] crc;
        crc = 16'h0000;
        add_byte(SOF_BYTE, drain_first);
        add_byte(SYNC_BYTE, 1'b0);
        add_byte(8'(body.size()), 1'b0);
        foreach (body[i]) begin
            crc = xmodem_fold(crc, body[i]);
            add_byte(body[i], 1'b0);
        end
        if (corrupt) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        add_byte(crc[15:8], 1'b0);
        add_byte(crc[7:0], 1'b0);
    endtask

    // Sender: presents the queued items, honouring each item's gap and any drain request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            tx_busy = 1'b0;
            tx_wait = -1;
        end else begin
            if (tx_busy && s_took) begin
                tx_busy = 1'b0;
            end
            if (!tx_busy && rx_bytes_q.size() != 0) begin
                if (tx_wait < 0) begin
                    tx_wait = rx_bytes_q[0].gap;
                end
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (!rx_bytes_q[0].drain || frame_evt_q.size() == 0) begin
                    tx_cur  = rx_bytes_q.pop_front();
                    tx_busy = 1'b1;
                    tx_wait = -1;
                end
            end
            s_axis_tvalid <= tx_busy;
            s_axis_tdata  <= tx_busy ? tx_cur.rx_byte : 8'($urandom);
        end
    end

    // Receiver: after each accepted item, holds tready low for a random wait, except in burst stretches.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_took) begin
                if (rx_mode_left == 0) begin
                    rx_burst     = !rx_burst;
                    rx_mode_left = $urandom_range(10, 50);
                end
                rx_mode_left--;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 13);
            end
            if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: the output is checked before the new input is predicted, so an item accepted
    // in the same cycle can never be matched against itself.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
            m_took <= 1'b0;
        end else begin
            s_took <= s_axis_tvalid && s_axis_tready;
            m_took <= m_axis_tvalid && m_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
            end
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_byte(s_axis_tdata);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("framed_serial_receiver_crc16 test failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] body[$];
        logic [7:0] b;
        int         pick;
        int         n;
        int         stop_at;
        bit         long_done;

        long_done = 1'b0;

        // Strays from the hunt, a repeated start byte followed by a broken pattern.
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(SOF_BYTE, 1'b0);
        add_byte(SOF_BYTE, 1'b0);
        add_byte(8'h41, 1'b0);
        // Zero-length frames, good and bad, then a short frame with extreme payload bytes and a bad one.
        body.delete();
        add_frame(body, 1'b0, 1'b0);
        add_frame(body, 1'b1, 1'b0);
        body = '{8'h00, 8'hFF};
        add_frame(body, 1'b0, 1'b0);
        body = '{8'hA5};
        add_frame(body, 1'b1, 1'b0);

        // The first random frame waits until the directed part has fully drained.
        stop_at = rx_bytes_q.size() + RANDOM_ITEMS;
        body.delete();
        repeat (3) body.insert(body.size(), 8'($urandom));
        add_frame(body, 1'b0, 1'b1);

        while (rx_bytes_q.size() < stop_at) begin
            pick = $urandom_range(0, 19);
            body.delete();
            if (!long_done && rx_bytes_q.size() > stop_at / 2) begin
                long_done = 1'b1;
                repeat (255) body.insert(body.size(), 8'($urandom));
                add_frame(body, 1'($urandom_range(0, 1)), 1'b1);
            end else if (pick <= 12) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
                repeat (n) body.insert(body.size(), 8'($urandom));
                add_frame(body, $urandom_range(0, 3) == 0, $urandom_range(0, 99) == 0);
            end else if (pick <= 15) begin
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom), 1'b0);
            end else if (pick <= 17) begin
                add_byte(SOF_BYTE, 1'b0);
                repeat ($urandom_range(0, 2)) add_byte(SOF_BYTE, 1'b0);
                b = 8'($urandom);
                if (b == SYNC_BYTE || b == SOF_BYTE) begin
                    b = 8'h7E;
                end
                add_byte(b, 1'b0);
            end else if (pick == 18) begin
                // A header whose frame is cut short; the following items fill it up.
                add_byte(SOF_BYTE, 1'b0);
                add_byte(SYNC_BYTE, 1'b0);
                add_byte(8'($urandom_range(2, 8)), 1'b0);
                add_byte(8'($urandom), 1'b0);
            end else begin
                add_byte(SOF_BYTE, 1'b0);
                repeat ($urandom_range(0, 6)) body.insert(body.size(), 8'($urandom));
                add_frame(body, $urandom_range(0, 3) == 0, 1'b0);
            end
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (rx_bytes_q.size() != 0 || tx_busy) begin
            @(posedge aclk);
        end
        while (frame_evt_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("framed_serial_receiver_crc16 test passed");
        end else begin
            $display("framed_serial_receiver_crc16 test failed");
        end
        $finish;
    end

endmodule

/* framed_serial_receiver_crc16.f */
src/fsrc_pkg.sv
src/fsrc_front.sv
src/fsrc_queue.sv
src/fsrc_back.sv
src/framed_serial_receiver_crc16.sv
tb/sv/framed_serial_receiver_crc16_tb.sv
